FILE: hw/rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int PRIO_BITS        = 8;
    localparam int ID_BITS          = 16;
    localparam int STATUS_BITS      = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     match_en;
    } t_cell_ctl;

endpackage

FILE: hw/rtl/sspq_cmd_if.sv
// ----------------------------------------------------------------------------
// sspq_cmd_if
// Command channel: one queue command per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sspq_cmd_if #(
    parameter int PAYLOAD_BITS = sspq_pkg::PAYLOAD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    cmd;
    logic [sspq_pkg::PRIO_BITS-1:0] prio;
    logic [sspq_pkg::ID_BITS-1:0]  proc_id;
    logic [PAYLOAD_BITS-1:0]       payload;

    modport source (output valid, output cmd, output prio, output proc_id,
                    output payload, input ready);
    modport sink   (input valid, input cmd, input prio, input proc_id,
                    input payload, output ready);
endinterface

FILE: hw/rtl/sspq_res_if.sv
// ----------------------------------------------------------------------------
// sspq_res_if
// Result channel: one result item per command, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sspq_res_if #(
    parameter int DEPTH        = sspq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = sspq_pkg::PAYLOAD_BITS_DEF
);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    logic                             valid;
    logic                             ready;
    logic [sspq_pkg::PRIO_BITS-1:0]   out_prio;
    logic [sspq_pkg::ID_BITS-1:0]     out_proc_id;
    logic [PAYLOAD_BITS-1:0]          out_payload;
    logic                             found;
    logic [sspq_pkg::STATUS_BITS-1:0] status;
    logic [COUNT_BITS-1:0]            count;

    modport source (output valid, output out_prio, output out_proc_id,
                    output out_payload, output found, output status,
                    output count, input ready);
    modport sink   (input valid, input out_prio, input out_proc_id,
                    input out_payload, input found, input status,
                    input count, output ready);
endinterface

FILE: hw/rtl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted chain: holds an entry, opens a gap for an insert,
// takes its right neighbour on a remove, and flags a process id match.
// ----------------------------------------------------------------------------
module sspq_cell #(
    parameter int INDEX        = 0,
    parameter int PAYLOAD_BITS = sspq_pkg::PAYLOAD_BITS_DEF,
    parameter int COUNT_BITS   = 5
) (
    input  logic                           i_clk,
    input  sspq_pkg::t_cell_ctl            i_ctl,
    input  logic [COUNT_BITS-1:0]          i_count,
    input  logic [sspq_pkg::PRIO_BITS-1:0] i_prio,
    input  logic [sspq_pkg::ID_BITS-1:0]   i_pid,
    input  logic [PAYLOAD_BITS-1:0]        i_pay,
    input  logic                           i_left_stay,
    input  logic [sspq_pkg::PRIO_BITS-1:0] i_left_prio,
    input  logic [sspq_pkg::ID_BITS-1:0]   i_left_pid,
    input  logic [PAYLOAD_BITS-1:0]        i_left_pay,
    input  logic [sspq_pkg::PRIO_BITS-1:0] i_right_prio,
    input  logic [sspq_pkg::ID_BITS-1:0]   i_right_pid,
    input  logic [PAYLOAD_BITS-1:0]        i_right_pay,
    output logic                           o_stay,
    output logic [sspq_pkg::PRIO_BITS-1:0] o_prio,
    output logic [sspq_pkg::ID_BITS-1:0]   o_pid,
    output logic [PAYLOAD_BITS-1:0]        o_pay,
    output logic                           o_match
);
    localparam logic [COUNT_BITS-1:0] SLOT = COUNT_BITS'(INDEX);

    logic [sspq_pkg::PRIO_BITS-1:0] r_prio;
    logic [sspq_pkg::ID_BITS-1:0]   r_pid;
    logic [PAYLOAD_BITS-1:0]        r_pay;
    logic                           r_match;
    logic                           w_occupied;
    logic                           w_stay;

    assign w_occupied = SLOT < i_count;
    // equal priority stays ahead of the newcomer
    assign w_stay     = w_occupied && (r_prio <= i_prio);

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            sspq_pkg::CELL_INSERT: begin
                if (!w_stay) begin
                    if (i_left_stay) begin
                        r_prio <= i_prio;
                        r_pid  <= i_pid;
                        r_pay  <= i_pay;
                    end else begin
                        r_prio <= i_left_prio;
                        r_pid  <= i_left_pid;
                        r_pay  <= i_left_pay;
                    end
                end
            end
            sspq_pkg::CELL_REMOVE: begin
                r_prio <= i_right_prio;
                r_pid  <= i_right_pid;
                r_pay  <= i_right_pay;
            end
            default: begin
            end
        endcase
        if (i_ctl.match_en) begin
            r_match <= w_occupied && (r_pid == i_pid);
        end
    end

    assign o_stay  = w_stay;
    assign o_prio  = r_prio;
    assign o_pid   = r_pid;
    assign o_pay   = r_pay;
    assign o_match = r_match;

endmodule

FILE: hw/rtl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded min-first queue of process entries held in a sorted chain of cells.
// ----------------------------------------------------------------------------
// Each command item passes through the idle, execute and fold states: in
// idle the accepting edge latches the command, in execute every cell of
// the chain is updated at once (insert, remove or id compare), and in
// fold the per-cell match flags are folded and the result register is
// loaded. A new item is taken only once the previous result is loaded and
// the block is back in idle, so items do not overlap; a full result
// register holds the block in its final step. Equal priorities leave in
// arrival order. Insert on a full queue and remove on an empty one report
// a status and change nothing. Clear only resets the entry count.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
    parameter int DEPTH        = sspq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_BITS = sspq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sspq_cmd_if.sink    i_cmd,
    sspq_res_if.source  o_res
);
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int PB         = sspq_pkg::PRIO_BITS;
    localparam int IB         = sspq_pkg::ID_BITS;
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FOLD
    } t_state;

    t_state                  r_state;
    sspq_pkg::t_cmd          r_cmd;
    logic [PB-1:0]           r_prio;
    logic [IB-1:0]           r_pid;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [COUNT_BITS-1:0]   r_count;

    logic [PB-1:0]           r_res_prio;
    logic [IB-1:0]           r_res_pid;
    logic [PAYLOAD_BITS-1:0] r_res_pay;
    sspq_pkg::t_status       r_res_status;

    logic                    r_out_valid;
    logic [PB-1:0]           r_out_prio;
    logic [IB-1:0]           r_out_pid;
    logic [PAYLOAD_BITS-1:0] r_out_pay;
    logic                    r_out_found;
    sspq_pkg::t_status       r_out_status;
    logic [COUNT_BITS-1:0]   r_out_count;

    sspq_pkg::t_cell_ctl     w_ctl;
    logic                    w_found;
    logic                    w_load;

    logic [PB-1:0]           w_prio  [DEPTH];
    logic [IB-1:0]           w_pid   [DEPTH];
    logic [PAYLOAD_BITS-1:0] w_pay   [DEPTH];
    logic [DEPTH-1:0]        w_stay;
    logic [DEPTH-1:0]        w_match;

    // cell control: broadcast to the whole chain during the execute step
    always_comb begin
        w_ctl.op       = sspq_pkg::CELL_HOLD;
        w_ctl.match_en = (r_state == S_EXEC);
        if (r_state == S_EXEC) begin
            if (r_cmd == sspq_pkg::CMD_INSERT && r_count != FULL_COUNT) begin
                w_ctl.op = sspq_pkg::CELL_INSERT;
            end else if (r_cmd == sspq_pkg::CMD_REMOVE && r_count != '0) begin
                w_ctl.op = sspq_pkg::CELL_REMOVE;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                    w_lstay;
            logic [PB-1:0]           w_lprio;
            logic [IB-1:0]           w_lpid;
            logic [PAYLOAD_BITS-1:0] w_lpay;
            logic [PB-1:0]           w_rprio;
            logic [IB-1:0]           w_rpid;
            logic [PAYLOAD_BITS-1:0] w_rpay;

            // the head sees a virtual neighbour that always holds its place
            if (g == 0) begin : g_head
                assign w_lstay = 1'b1;
                assign w_lprio = r_prio;
                assign w_lpid  = r_pid;
                assign w_lpay  = r_pay;
            end else begin : g_body
                assign w_lstay = w_stay[g-1];
                assign w_lprio = w_prio[g-1];
                assign w_lpid  = w_pid[g-1];
                assign w_lpay  = w_pay[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_rprio = '0;
                assign w_rpid  = '0;
                assign w_rpay  = '0;
            end else begin : g_inner
                assign w_rprio = w_prio[g+1];
                assign w_rpid  = w_pid[g+1];
                assign w_rpay  = w_pay[g+1];
            end

            sspq_cell #(
                .INDEX        (g),
                .PAYLOAD_BITS (PAYLOAD_BITS),
                .COUNT_BITS   (COUNT_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_count      (r_count),
                .i_prio       (r_prio),
                .i_pid        (r_pid),
                .i_pay        (r_pay),
                .i_left_stay  (w_lstay),
                .i_left_prio  (w_lprio),
                .i_left_pid   (w_lpid),
                .i_left_pay   (w_lpay),
                .i_right_prio (w_rprio),
                .i_right_pid  (w_rpid),
                .i_right_pay  (w_rpay),
                .o_stay       (w_stay[g]),
                .o_prio       (w_prio[g]),
                .o_pid        (w_pid[g]),
                .o_pay        (w_pay[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    assign w_found = (r_cmd == sspq_pkg::CMD_CHECK) && (|w_match);
    assign w_load  = (r_state == S_FOLD) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd   <= sspq_pkg::t_cmd'(i_cmd.cmd);
                        r_prio  <= i_cmd.prio;
                        r_pid   <= i_cmd.proc_id;
                        r_pay   <= i_cmd.payload;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_prio   <= '0;
                    r_res_pid    <= '0;
                    r_res_pay    <= '0;
                    r_res_status <= sspq_pkg::ST_OK;
                    case (r_cmd)
                        sspq_pkg::CMD_INSERT: begin
                            if (r_count == FULL_COUNT) begin
                                r_res_status <= sspq_pkg::ST_FULL;
                            end else begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                        sspq_pkg::CMD_REMOVE: begin
                            if (r_count == '0) begin
                                r_res_status <= sspq_pkg::ST_EMPTY;
                            end else begin
                                r_res_prio <= w_prio[0];
                                r_res_pid  <= w_pid[0];
                                r_res_pay  <= w_pay[0];
                                r_count    <= r_count - 1'b1;
                            end
                        end
                        sspq_pkg::CMD_CLEAR: begin
                            r_count <= '0;
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    // hold until the result register is free
                    if (w_load) begin
                        r_out_prio   <= r_res_prio;
                        r_out_pid    <= r_res_pid;
                        r_out_pay    <= r_res_pay;
                        r_out_found  <= w_found;
                        r_out_status <= r_res_status;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.out_prio    = r_out_prio;
    assign o_res.out_proc_id = r_out_pid;
    assign o_res.out_payload = r_out_pay;
    assign o_res.found       = r_out_found;
    assign o_res.status      = r_out_status;
    assign o_res.count       = r_out_count;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("entry count beyond depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd == sspq_pkg::CMD_INSERT && r_count != FULL_COUNT)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not add one entry");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == sspq_pkg::ST_EMPTY)
        |-> (o_res.count == '0 && o_res.out_prio == '0 && o_res.out_proc_id == '0))
        else $error("remove on empty queue reported an entry");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.found)
        |-> (o_res.status == sspq_pkg::ST_OK && o_res.count != '0))
        else $error("match reported on an empty queue");
`endif

endmodule
